// ===== design/fs_pkg.sv =====
package fs_pkg;

    localparam int unsigned MaxLen    = 65536;
    localparam int unsigned MaxFields = 256;
    localparam int unsigned PosW      = 17;
    localparam int unsigned SlotW     = 9;
    localparam int unsigned TotW      = 17;
    localparam int unsigned QDepth    = 4;
    localparam int unsigned QPtrW     = 2;

    localparam logic [2:0] CfgSepCount = 3'd0;
    localparam logic [2:0] CfgSepA     = 3'd1;
    localparam logic [2:0] CfgSepB     = 3'd2;
    localparam logic [2:0] CfgSepC     = 3'd3;
    localparam logic [2:0] CfgSepD     = 3'd4;
    localparam logic [2:0] CfgMaxFld   = 3'd5;

    localparam logic KindByte = 1'b0;
    localparam logic KindEnd  = 1'b1;

    // Classified item passed from the front end to the back end.
    typedef struct packed {
        logic       kind;
        logic       sep;
        logic [1:0] mode;   // 0 whitespace, 1 single, 2 set
    } t_cls;

    typedef struct packed {
        logic              result_kind;
        logic [7:0]        field_index;
        logic [15:0]       field_start;
        logic [15:0]       field_length;
        logic [TotW-1:0]   total_fields;
        logic              too_long;
        logic              last;
    } t_res;

    function automatic logic [15:0] sat16(input logic [PosW-1:0] v);
        sat16 = v[PosW-1] ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic [PosW-1:0] span(input logic [PosW-1:0] f,
                                             input logic [PosW-1:0] t);
        span = (t >= f) ? (t - f) : '0;
    endfunction

endpackage

// ===== design/field_splitter_top.sv =====
// Awk-style field splitter. Bytes of a string enter on the s_axis channel
// (tuser 0, tdata the byte); a transaction with tuser 1 closes the string.
// For each stored field one report leaves on m_axis (tuser 0) with slot,
// start and length; after the end transaction a count report (tuser 1,
// tlast 1) gives the total number of fields. Configuration is written
// through i_cfg_we / i_cfg_addr / i_cfg_data; the user must write it only
// while the block is idle, which the block itself does not enforce.
// Throughput is one byte per cycle unless the output buffer fills: the
// front end classifies a byte against the separators and pushes it into a
// four-entry queue; the back end updates the field state. An end
// transaction yields up to two results. Synchronous active-low reset clears
// the queues and the string state and loads default configuration. When the
// receiver stalls, results wait in a two-entry output buffer, then the queue
// fills and s_axis_tready drops; nothing is lost.
module field_splitter_top import fs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_byte
    input  logic        s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // field_index[7:0], field_start[23:8], field_length[39:24],
    // total_fields[56:40], too_long[57], zero fill to 64 bits
    output logic [63:0] m_axis_tdata,
    output logic        m_axis_tuser,   // result_kind
    output logic        m_axis_tlast,   // last
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [8:0]  i_cfg_data
);
    logic [2:0] r_sep_count;
    logic [7:0] r_sep_a, r_sep_b, r_sep_c, r_sep_d;
    logic [8:0] r_max_fields;
    logic       w_qv, w_qr;
    t_cls       w_cls;
    t_res       w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep_count <= 3'd0; r_sep_a <= 8'd32; r_sep_b <= 8'd9;
            r_sep_c <= 8'd44; r_sep_d <= 8'd59; r_max_fields <= 9'd16;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CfgSepCount: r_sep_count  <= i_cfg_data[2:0];
                CfgSepA:     r_sep_a      <= i_cfg_data[7:0];
                CfgSepB:     r_sep_b      <= i_cfg_data[7:0];
                CfgSepC:     r_sep_c      <= i_cfg_data[7:0];
                CfgSepD:     r_sep_d      <= i_cfg_data[7:0];
                CfgMaxFld:   r_max_fields <= i_cfg_data;
                default: ;
            endcase
        end
    end

    fs_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_kind(s_axis_tuser), .i_char(s_axis_tdata),
        .i_sep_count(r_sep_count), .i_sep_a(r_sep_a), .i_sep_b(r_sep_b),
        .i_sep_c(r_sep_c), .i_sep_d(r_sep_d),
        .o_valid(w_qv), .i_ready(w_qr), .o_cls(w_cls)
    );

    fs_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(w_qv), .o_ready(w_qr), .i_cls(w_cls),
        .i_max_fields(r_max_fields),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(w_res)
    );

    assign m_axis_tdata = {6'd0, w_res.too_long, w_res.total_fields,
                           w_res.field_length, w_res.field_start, w_res.field_index};
    assign m_axis_tuser = w_res.result_kind;
    assign m_axis_tlast = w_res.last;
endmodule

// ===== design/fs_front.sv =====
module fs_front import fs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [7:0]  i_char,
    input  logic [2:0]  i_sep_count,
    input  logic [7:0]  i_sep_a,
    input  logic [7:0]  i_sep_b,
    input  logic [7:0]  i_sep_c,
    input  logic [7:0]  i_sep_d,
    output logic        o_valid,
    input  logic        i_ready,
    output t_cls        o_cls
);
    logic [QDepth-1:0][$bits(t_cls)-1:0] r_q;
    logic [QPtrW-1:0] r_wp, r_rp;
    logic [QPtrW:0]   r_cnt;
    t_cls             w_cls;
    logic             w_push, w_pop;
    logic [2:0]       w_m;

    always_comb begin
        w_m = (i_sep_count > 3'd4) ? 3'd4 : i_sep_count;
        w_cls.kind = i_kind;
        w_cls.mode = (w_m == 3'd0) ? 2'd0 : (w_m == 3'd1) ? 2'd1 : 2'd2;
        unique case (w_m)
            3'd0:    w_cls.sep = (i_char == 8'd32) || (i_char == 8'd9);
            3'd1:    w_cls.sep = (i_char == i_sep_a);
            3'd2:    w_cls.sep = (i_char == i_sep_a) || (i_char == i_sep_b);
            3'd3:    w_cls.sep = (i_char == i_sep_a) || (i_char == i_sep_b)
                              || (i_char == i_sep_c);
            default: w_cls.sep = (i_char == i_sep_a) || (i_char == i_sep_b)
                              || (i_char == i_sep_c) || (i_char == i_sep_d);
        endcase
    end

    assign o_ready = (r_cnt != QDepth[QPtrW:0]);
    assign o_valid = (r_cnt != '0);
    assign o_cls   = t_cls'(r_q[r_rp]);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_cls;
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + {{QPtrW{1'b0}}, w_push} - {{QPtrW{1'b0}}, w_pop};
        end
    end
endmodule

// ===== design/fs_back.sv =====
module fs_back import fs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_cls        i_cls,
    input  logic [8:0]  i_max_fields,
    output logic        o_valid,
    input  logic        i_ready,
    output t_res        o_res
);
    // Field state of the string under way.
    logic [PosW-1:0]  r_pos, r_begin, r_lne;
    logic [SlotW-1:0] r_slot;
    logic [TotW-1:0]  r_total;
    logic r_run, r_full, r_taf, r_saw, r_ovf;

    // Two-entry output queue: an item gives at most two results.
    t_res       r_ob [2];
    logic       r_orp;
    logic [1:0] r_ocnt;

    logic [PosW-1:0]  n_pos, n_begin, n_lne;
    logic [SlotW-1:0] n_slot;
    logic [TotW-1:0]  n_total;
    logic n_run, n_full, n_taf, n_saw, n_ovf;
    logic [1:0] w_nres;
    t_res w_r0, w_r1;
    logic [SlotW-1:0] w_lim;
    logic [PosW-1:0]  w_p, w_stop;
    logic w_take, w_pop, w_open, w_open2, w_emit_a, w_emit_b;
    logic [PosW-1:0] w_ob, w_ob2;
    logic [7:0] w_idx;

    assign w_lim = (i_max_fields == '0) ? 9'd1 :
                   (i_max_fields > MaxFields[SlotW-1:0]) ? MaxFields[SlotW-1:0] : i_max_fields;

    // Accept only when the output queue holds room for two results.
    assign o_ready = (r_ocnt == 2'd0) || ((r_ocnt == 2'd1) && i_ready);
    assign w_take  = i_valid && o_ready;
    assign o_valid = (r_ocnt != 2'd0);
    assign o_res   = r_ob[r_orp];
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        logic [SlotW-1:0] s1;
        logic f1;
        n_pos = r_pos; n_begin = r_begin; n_lne = r_lne; n_slot = r_slot;
        n_total = r_total; n_run = r_run; n_full = r_full; n_taf = r_taf;
        n_saw = r_saw; n_ovf = r_ovf;
        w_open = 1'b0; w_open2 = 1'b0; w_ob = '0; w_ob2 = '0;
        w_emit_a = 1'b0; w_emit_b = 1'b0; w_stop = '0; w_nres = 2'd0;
        w_p = r_pos;
        s1 = r_slot; f1 = r_full;
        w_r0 = '0; w_r1 = '0;
        if (i_cls.kind == KindByte) begin
            if (r_pos >= MaxLen[PosW-1:0]) begin
                n_ovf = 1'b1; w_p = MaxLen[PosW-1:0];
            end else begin
                n_pos = r_pos + 1'b1;
            end
            if (i_cls.mode == 2'd1) begin
                w_open = !r_saw; w_ob = w_p;
                w_emit_a = i_cls.sep;
                w_open2 = i_cls.sep; w_ob2 = n_pos;
            end else if (!r_saw) begin
                if (!(i_cls.sep && i_cls.mode == 2'd0)) begin
                    w_open = 1'b1; w_ob = w_p;
                    w_emit_a = i_cls.sep;
                    n_run = i_cls.sep;
                    if (!i_cls.sep) n_lne = n_pos;
                end
            end else if (i_cls.sep) begin
                w_emit_a = !r_run;
                n_run = 1'b1;
            end else begin
                w_open = r_run; w_ob = w_p;
                n_run = 1'b0;
                n_lne = n_pos;
            end
        end else begin
            w_emit_b = r_saw;
            w_open = r_saw && (i_cls.mode == 2'd2) && r_run; w_ob = r_pos;
        end
        // First field opening, then the emit on the opened state.
        if (w_open) begin
            if (n_total != '1) n_total = n_total + 1'b1;
            if (!r_full) begin
                s1 = r_slot + 1'b1; n_begin = w_ob;
                f1 = (s1 >= w_lim);
            end else n_taf = 1'b1;
            n_saw = 1'b1;
        end
        n_slot = s1; n_full = f1;
        w_idx = (s1 != '0) ? 8'(s1 - 1'b1) : 8'd0;
        w_r0.too_long = n_ovf;
        w_r1.too_long = n_ovf;
        if (i_cls.kind == KindByte) begin
            if (w_emit_a && !f1) begin
                w_r0.field_index  = w_idx;
                w_r0.field_start  = sat16(n_begin);
                w_r0.field_length = sat16(span(n_begin, w_p));
                w_nres = 2'd1;
            end
            if (w_open2) begin
                if (n_total != '1) n_total = n_total + 1'b1;
                if (!f1) begin
                    n_slot = s1 + 1'b1; n_begin = w_ob2;
                    n_full = (n_slot >= w_lim);
                end else n_taf = 1'b1;
            end
        end else begin
            w_r1.result_kind = 1'b1;
            w_r1.total_fields = n_total;
            w_r1.last = 1'b1;
            if (i_cls.mode == 2'd0) begin
                w_stop = (r_full && !r_taf) ? r_lne : r_pos;
                w_emit_b = r_saw && !(r_run && !r_full);
            end else w_stop = r_pos;
            w_r0.field_index  = w_idx;
            w_r0.field_start  = sat16(n_begin);
            w_r0.field_length = sat16(span(n_begin, w_stop));
            if (w_emit_b) w_nres = 2'd2;
            else begin w_r0 = w_r1; w_nres = 2'd1; end
            n_pos = '0; n_begin = '0; n_lne = '0; n_slot = '0; n_total = '0;
            n_run = 1'b0; n_full = 1'b0; n_taf = 1'b0; n_saw = 1'b0; n_ovf = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_nres != 2'd0) begin
            // Entries are placed after any result still waiting.
            if (r_ocnt == 2'd1 && !w_pop) begin
                r_ob[~r_orp] <= w_r0;
            end else if (r_ocnt == 2'd1) begin
                r_ob[~r_orp] <= w_r0;
                r_ob[r_orp]  <= w_r1;
            end else begin
                r_ob[r_orp]  <= w_r0;
                r_ob[~r_orp] <= w_r1;
            end
        end
        if (!i_rst_n) begin
            r_pos <= '0; r_begin <= '0; r_lne <= '0; r_slot <= '0; r_total <= '0;
            r_run <= 1'b0; r_full <= 1'b0; r_taf <= 1'b0; r_saw <= 1'b0;
            r_ovf <= 1'b0; r_orp <= 1'b0; r_ocnt <= 2'd0;
        end else begin
            if (w_take) begin
                r_pos <= n_pos; r_begin <= n_begin; r_lne <= n_lne;
                r_slot <= n_slot; r_total <= n_total; r_run <= n_run;
                r_full <= n_full; r_taf <= n_taf; r_saw <= n_saw; r_ovf <= n_ovf;
            end
            if (w_pop) r_orp <= ~r_orp;
            r_ocnt <= r_ocnt + (w_take ? w_nres : 2'd0) - {1'b0, w_pop};
        end
    end
endmodule
